### hdl/sfce_pkg.sv
// ----------------------------------------------------------------------------
// sfce_pkg
// Shared types, codes and helpers for the SPI flash command engine.
// ----------------------------------------------------------------------------
package sfce_pkg;

  // Default page size in bytes
  localparam int PAGE_BYTES_DEF = 256;

  // Most result items one input item can cause (erase: header, deselect, poll)
  localparam int MAX_RES = 7;
  localparam int RES_CNT_W = $clog2(MAX_RES + 1);

  // Host function codes
  localparam logic [2:0] FN_READ_ID   = 3'd0;
  localparam logic [2:0] FN_WREN      = 3'd1;
  localparam logic [2:0] FN_ERASE     = 3'd2;
  localparam logic [2:0] FN_READ      = 3'd3;
  localparam logic [2:0] FN_PROG      = 3'd4;
  localparam logic [2:0] FN_PROG_BYTE = 3'd5;
  localparam logic [2:0] FN_FLASH_BYTE = 3'd6;

  // SPI action codes
  localparam logic [2:0] OP_SEND  = 3'd0;
  localparam logic [2:0] OP_RECV  = 3'd1;
  localparam logic [2:0] OP_DESEL = 3'd2;
  localparam logic [2:0] OP_FILL  = 3'd3;
  localparam logic [2:0] OP_NONE  = 3'd4;

  // Flash opcodes
  localparam logic [7:0] CMD_RDID  = 8'h9F;
  localparam logic [7:0] CMD_WREN  = 8'h06;
  localparam logic [7:0] CMD_SE    = 8'hD8;
  localparam logic [7:0] CMD_READ  = 8'h03;
  localparam logic [7:0] CMD_PP    = 8'h02;
  localparam logic [7:0] CMD_RDSR  = 8'h05;

  // One result item (last is derived by the sequencer)
  typedef struct packed {
    logic [2:0]  spi_op;
    logic [7:0]  tx_byte;
    logic [8:0]  fill_count;
    logic        host_valid;
    logic [7:0]  host_byte;
    logic [23:0] id_value;
    logic        done_res;
    logic        error;
  } sfce_res_t;

  // Result list for one input item, entry 0 goes out first
  typedef struct packed {
    sfce_res_t [MAX_RES-1:0] res;
    logic [RES_CNT_W-1:0]    n;
  } sfce_list_t;

  // Plain action with an optional byte to send
  function automatic sfce_res_t mk_res(input logic [2:0] op, input logic [7:0] tx);
    sfce_res_t r;
    r = '0;
    r.spi_op = op;
    r.tx_byte = tx;
    return r;
  endfunction

  // Rejected item
  function automatic sfce_res_t mk_reject();
    sfce_res_t r;
    r = '0;
    r.spi_op = OP_NONE;
    r.error = 1'b1;
    return r;
  endfunction

endpackage

### hdl/sfce_ctrl.sv
// ----------------------------------------------------------------------------
// sfce_ctrl
// Phase machine and decoder: builds the result list for an accepted item.
// ----------------------------------------------------------------------------
module sfce_ctrl #(
  parameter int PAGE_BYTES = sfce_pkg::PAGE_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [2:0]          in_func,
  input  logic [23:0]         in_address,
  input  logic [20:0]         in_count,
  input  logic [7:0]          in_data_byte,
  output sfce_pkg::sfce_list_t list
);

  localparam int PadW = $clog2(PAGE_BYTES + 1);
  localparam logic [20:0] PageCnt = 21'(PAGE_BYTES);

  // Phase codes
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_ID     = 3'd1;
  localparam logic [2:0] PH_READ   = 3'd2;
  localparam logic [2:0] PH_PROG   = 3'd3;
  localparam logic [2:0] PH_STATUS = 3'd4;

  logic [2:0]      phase_r, phase_nxt;
  logic [20:0]     remaining_r, remaining_nxt;
  logic [23:0]     id_acc_r, id_acc_nxt;
  logic [1:0]      id_idx_r, id_idx_nxt;
  logic [PadW-1:0] pad_r, pad_nxt;

  logic [20:0] rem_dec;
  logic [23:0] acc_shift;
  logic [1:0]  idx_inc;
  sfce_pkg::sfce_res_t desel_done;

  assign rem_dec   = remaining_r - 21'd1;
  assign acc_shift = {id_acc_r[15:0], in_data_byte};
  assign idx_inc   = id_idx_r + 2'd1;

  // Decode of the current item against the phase
  always_comb begin
    phase_nxt     = phase_r;
    remaining_nxt = remaining_r;
    id_acc_nxt    = id_acc_r;
    id_idx_nxt    = id_idx_r;
    pad_nxt       = pad_r;
    list          = '0;
    list.n        = sfce_pkg::RES_CNT_W'(1);
    list.res[0]   = sfce_pkg::mk_reject();
    desel_done    = sfce_pkg::mk_res(sfce_pkg::OP_DESEL, 8'h00);
    desel_done.done_res = 1'b1;

    if (in_func <= sfce_pkg::FN_PROG && phase_r != PH_IDLE) begin
      // command while busy: reject
    end else begin
      unique case (in_func)
        sfce_pkg::FN_READ_ID: begin
          list.res[0] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_RDID);
          list.res[1] = sfce_pkg::mk_res(sfce_pkg::OP_RECV, 8'h00);
          list.n      = sfce_pkg::RES_CNT_W'(2);
          id_acc_nxt  = '0;
          id_idx_nxt  = '0;
          phase_nxt   = PH_ID;
        end
        sfce_pkg::FN_WREN: begin
          list.res[0] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_WREN);
          list.res[1] = desel_done;
          list.n      = sfce_pkg::RES_CNT_W'(2);
        end
        sfce_pkg::FN_ERASE: begin
          list.res[0] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_SE);
          list.res[1] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[23:16]);
          list.res[2] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[15:8]);
          list.res[3] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[7:0]);
          list.res[4] = sfce_pkg::mk_res(sfce_pkg::OP_DESEL, 8'h00);
          list.res[5] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_RDSR);
          list.res[6] = sfce_pkg::mk_res(sfce_pkg::OP_RECV, 8'h00);
          list.n      = sfce_pkg::RES_CNT_W'(7);
          phase_nxt   = PH_STATUS;
        end
        sfce_pkg::FN_READ: begin
          list.res[0] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_READ);
          list.res[1] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[23:16]);
          list.res[2] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[15:8]);
          list.res[3] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[7:0]);
          list.n      = sfce_pkg::RES_CNT_W'(5);
          if (in_count == 21'd0) begin
            // empty read: header then deselect
            list.res[4] = desel_done;
          end else begin
            list.res[4]   = sfce_pkg::mk_res(sfce_pkg::OP_RECV, 8'h00);
            remaining_nxt = in_count;
            phase_nxt     = PH_READ;
          end
        end
        sfce_pkg::FN_PROG: begin
          if (in_count != 21'd0 && in_count <= PageCnt) begin
            list.res[0]   = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_PP);
            list.res[1]   = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[23:16]);
            list.res[2]   = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[15:8]);
            list.res[3]   = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_address[7:0]);
            list.n        = sfce_pkg::RES_CNT_W'(4);
            remaining_nxt = in_count;
            pad_nxt       = PadW'(PageCnt - in_count);
            phase_nxt     = PH_PROG;
          end
        end
        sfce_pkg::FN_PROG_BYTE: begin
          if (phase_r == PH_PROG) begin
            list.res[0]   = sfce_pkg::mk_res(sfce_pkg::OP_SEND, in_data_byte);
            remaining_nxt = rem_dec;
            if (rem_dec == 21'd0) begin
              phase_nxt = PH_STATUS;
              if (pad_r != '0) begin
                // pad the rest of the page with 0xFF
                list.res[1] = sfce_pkg::mk_res(sfce_pkg::OP_FILL, 8'h00);
                list.res[1].fill_count = 9'(pad_r);
                list.res[2] = sfce_pkg::mk_res(sfce_pkg::OP_DESEL, 8'h00);
                list.res[3] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_RDSR);
                list.res[4] = sfce_pkg::mk_res(sfce_pkg::OP_RECV, 8'h00);
                list.n      = sfce_pkg::RES_CNT_W'(5);
              end else begin
                list.res[1] = sfce_pkg::mk_res(sfce_pkg::OP_DESEL, 8'h00);
                list.res[2] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_RDSR);
                list.res[3] = sfce_pkg::mk_res(sfce_pkg::OP_RECV, 8'h00);
                list.n      = sfce_pkg::RES_CNT_W'(4);
              end
            end
          end
        end
        sfce_pkg::FN_FLASH_BYTE: begin
          if (phase_r == PH_ID) begin
            id_acc_nxt = acc_shift;
            if (idx_inc == 2'd3) begin
              list.res[0] = desel_done;
              list.res[0].id_value = acc_shift;
              id_idx_nxt = '0;
              phase_nxt  = PH_IDLE;
            end else begin
              list.res[0] = sfce_pkg::mk_res(sfce_pkg::OP_RECV, 8'h00);
              id_idx_nxt  = idx_inc;
            end
          end else if (phase_r == PH_READ) begin
            remaining_nxt = rem_dec;
            if (rem_dec == 21'd0) begin
              list.res[0] = desel_done;
              phase_nxt   = PH_IDLE;
            end else begin
              list.res[0] = sfce_pkg::mk_res(sfce_pkg::OP_RECV, 8'h00);
            end
            list.res[0].host_valid = 1'b1;
            list.res[0].host_byte  = in_data_byte;
          end else if (phase_r == PH_STATUS) begin
            if (in_data_byte[0]) begin
              // still busy: poll again
              list.res[0] = sfce_pkg::mk_res(sfce_pkg::OP_DESEL, 8'h00);
              list.res[1] = sfce_pkg::mk_res(sfce_pkg::OP_SEND, sfce_pkg::CMD_RDSR);
              list.res[2] = sfce_pkg::mk_res(sfce_pkg::OP_RECV, 8'h00);
              list.n      = sfce_pkg::RES_CNT_W'(3);
            end else begin
              list.res[0] = desel_done;
              phase_nxt   = PH_IDLE;
            end
          end
        end
        default: begin
          // unknown function: reject
        end
      endcase
    end
  end

  // Phase state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      remaining_r <= '0;
      id_acc_r    <= '0;
      id_idx_r    <= '0;
      pad_r       <= '0;
    end else if (in_fire) begin
      phase_r     <= phase_nxt;
      remaining_r <= remaining_nxt;
      id_acc_r    <= id_acc_nxt;
      id_idx_r    <= id_idx_nxt;
      pad_r       <= pad_nxt;
    end
  end

endmodule

### hdl/sfce_seq.sv
// ----------------------------------------------------------------------------
// sfce_seq
// Result register: holds the list of one item and shifts it out in order.
// ----------------------------------------------------------------------------
module sfce_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sfce_pkg::sfce_list_t list,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sfce_pkg::sfce_res_t  out_res,
  output logic                 out_last
);

  sfce_pkg::sfce_res_t [sfce_pkg::MAX_RES-1:0] buf_r;
  logic [sfce_pkg::RES_CNT_W-1:0]              cnt_r;
  logic                                         load;
  logic                                         out_fire;

  assign out_valid = (cnt_r != '0);
  assign out_last  = (cnt_r == sfce_pkg::RES_CNT_W'(1));
  assign out_res   = buf_r[0];
  assign out_fire  = out_valid && out_ready;
  // take a new item once the final result of the previous one leaves
  assign in_ready  = !out_valid || (out_last && out_ready);
  assign load      = in_valid && in_ready;

  // Pending count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (load) begin
      cnt_r <= list.n;
    end else if (out_fire) begin
      cnt_r <= cnt_r - sfce_pkg::RES_CNT_W'(1);
    end
  end

  // Result entries, shifted towards entry 0
  always_ff @(posedge clk) begin
    if (load) begin
      buf_r <= list.res;
    end else if (out_fire) begin
      for (int i = 0; i < sfce_pkg::MAX_RES - 1; i++) begin
        buf_r[i] <= buf_r[i+1];
      end
    end
  end

endmodule

### hdl/spi_flash_command_engine.sv
// ----------------------------------------------------------------------------
// spi_flash_command_engine
// Byte-level SPI NOR flash command sequencer for an external byte shifter.
// ----------------------------------------------------------------------------
// Usage:
//   The in_ channel carries host commands (read ID, write enable, erase, read,
//   page program, program data) and the bytes the flash returns (flash byte).
//   The out_ channel carries SPI byte actions (send, receive slot, deselect,
//   0xFF fill, none) with read data, the JEDEC id and done/error flags;
//   out_tlast marks the final result of each input transaction.
//   An item causes one to seven results. The phase machine decodes an item
//   in the cycle it is accepted; its results sit in a result register and
//   leave one per cycle while out_tready is high; the first is offered in
//   the cycle after acceptance. A new item is accepted in the same cycle
//   as the final result of the previous one is taken, and never earlier,
//   so the single result port sets the pace.
//   If the receiver stalls, the pending results hold and in_tready stays low
//   until the last of them is taken.
//   Reset returns to the idle phase with no results pending.
// ----------------------------------------------------------------------------
module spi_flash_command_engine #(
  parameter int PAGE_BYTES = sfce_pkg::PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // address[23:0], count[44:24], data_byte[52:45]
  input  logic [2:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // tx_byte[7:0], fill_count[16:8], host_valid[17],
                                  // host_byte[25:18], id_value[49:26], done_res[50],
                                  // error[51]
  output logic [2:0]  out_tuser,  // spi_op
  output logic        out_tlast
);

  sfce_pkg::sfce_list_t list;
  sfce_pkg::sfce_res_t  res;
  logic                 in_fire;

  assign in_fire = in_tvalid && in_tready;

  // Phase machine and decode
  sfce_ctrl #(
    .PAGE_BYTES(PAGE_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_func      (in_tuser),
    .in_address   (in_tdata[23:0]),
    .in_count     (in_tdata[44:24]),
    .in_data_byte (in_tdata[52:45]),
    .list         (list)
  );

  // Result register and output sequencing
  sfce_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .list      (list),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  // Output packing
  assign out_tuser = res.spi_op;
  assign out_tdata = {4'b0000, res.error, res.done_res, res.id_value, res.host_byte,
                      res.host_valid, res.fill_count, res.tx_byte};

  // An empty result register always takes a new item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("in_tready low with no results pending");

  // A rejected item gives a single no-op result
  a_error_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[51] |-> out_tuser == sfce_pkg::OP_NONE && out_tlast)
    else $error("error result not a lone no-op");

  // Completion is always the final result of its item
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[50] |-> out_tlast && out_tuser == sfce_pkg::OP_DESEL)
    else $error("done result not a final deselect");

  // Read data only comes with a receive slot or the closing deselect
  a_host_data_op: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[17] |->
      (out_tuser == sfce_pkg::OP_RECV || out_tuser == sfce_pkg::OP_DESEL) && out_tlast)
    else $error("host data on unexpected action");

endmodule

### dv/sfce_checker.sv
// ----------------------------------------------------------------------------
// sfce_checker
// Watches both streams of the SPI flash command engine, works out the SPI
// actions each accepted command or flash byte should cause, and compares every
// result transaction field by field with the oldest outstanding action.
// ----------------------------------------------------------------------------
module sfce_checker
  import sfce_pkg::*;
#(
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [55:0] in_tdata,   // address[23:0], count[44:24], data_byte[52:45]
  input  logic [2:0]  in_tuser,   // func
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [55:0] out_tdata,  // tx_byte[7:0], fill_count[16:8], host_valid[17],
                                  // host_byte[25:18], id_value[49:26], done_res[50],
                                  // error[51]
  input  logic [2:0]  out_tuser,  // spi_op
  input  logic        out_tlast,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_ID,
    ENG_READ,
    ENG_PROG,
    ENG_STATUS
  } eng_phase_e;

  typedef struct packed {
    sfce_res_t act;
    logic      last;
  } spi_action_t;

  // Shadow of the engine state
  eng_phase_e  eng_phase;
  logic [20:0] read_left;
  logic [23:0] id_shift;
  logic [1:0]  id_count;
  logic [8:0]  fill_left;

  // Actions caused by the transaction being decoded, and all still owed
  sfce_res_t   item_actions[$];
  spi_action_t expected_actions[$];

  function automatic sfce_res_t spi_act(input logic [2:0] op, input logic [7:0] tx);
    sfce_res_t r;
    r = '0;
    r.spi_op = op;
    r.tx_byte = tx;
    return r;
  endfunction

  task add_reject();
    sfce_res_t r;
    r = spi_act(OP_NONE, 8'h00);
    r.error = 1'b1;
    item_actions.push_back(r);
  endtask

  task add_done();
    sfce_res_t r;
    r = spi_act(OP_DESEL, 8'h00);
    r.done_res = 1'b1;
    item_actions.push_back(r);
  endtask

  task add_header(input logic [7:0] cmd, input logic [23:0] addr);
    item_actions.push_back(spi_act(OP_SEND, cmd));
    item_actions.push_back(spi_act(OP_SEND, addr[23:16]));
    item_actions.push_back(spi_act(OP_SEND, addr[15:8]));
    item_actions.push_back(spi_act(OP_SEND, addr[7:0]));
  endtask

  // Deselect, then read status register again
  task add_status_poll();
    item_actions.push_back(spi_act(OP_DESEL, 8'h00));
    item_actions.push_back(spi_act(OP_SEND, CMD_RDSR));
    item_actions.push_back(spi_act(OP_RECV, 8'h00));
    eng_phase = ENG_STATUS;
  endtask

  // Decode one input transaction into the SPI actions it should cause
  task plan_actions(input logic [2:0] fn, input logic [23:0] addr,
                    input logic [20:0] cnt, input logic [7:0] dbyte);
    sfce_res_t r;
    item_actions.delete();
    if (fn <= FN_PROG && eng_phase != ENG_IDLE) begin
      add_reject();
    end else begin
      case (fn)
        FN_READ_ID: begin
          item_actions.push_back(spi_act(OP_SEND, CMD_RDID));
          item_actions.push_back(spi_act(OP_RECV, 8'h00));
          id_shift = '0;
          id_count = '0;
          eng_phase = ENG_ID;
        end
        FN_WREN: begin
          item_actions.push_back(spi_act(OP_SEND, CMD_WREN));
          add_done();
        end
        FN_ERASE: begin
          add_header(CMD_SE, addr);
          add_status_poll();
        end
        FN_READ: begin
          add_header(CMD_READ, addr);
          if (cnt == '0) begin
            add_done();
          end else begin
            item_actions.push_back(spi_act(OP_RECV, 8'h00));
            read_left = cnt;
            eng_phase = ENG_READ;
          end
        end
        FN_PROG: begin
          if (cnt == '0 || cnt > PAGE_BYTES) begin
            add_reject();
          end else begin
            add_header(CMD_PP, addr);
            read_left = cnt;
            fill_left = 9'(PAGE_BYTES - cnt);
            eng_phase = ENG_PROG;
          end
        end
        FN_PROG_BYTE: begin
          if (eng_phase != ENG_PROG) begin
            add_reject();
          end else begin
            item_actions.push_back(spi_act(OP_SEND, dbyte));
            read_left = read_left - 21'd1;
            if (read_left == '0) begin
              if (fill_left != '0) begin
                r = spi_act(OP_FILL, 8'h00);
                r.fill_count = fill_left;
                item_actions.push_back(r);
              end
              add_status_poll();
            end
          end
        end
        FN_FLASH_BYTE: begin
          case (eng_phase)
            ENG_ID: begin
              id_shift = {id_shift[15:0], dbyte};
              id_count = id_count + 2'd1;
              if (id_count == 2'd3) begin
                r = spi_act(OP_DESEL, 8'h00);
                r.id_value = id_shift;
                r.done_res = 1'b1;
                item_actions.push_back(r);
                id_count = '0;
                eng_phase = ENG_IDLE;
              end else begin
                item_actions.push_back(spi_act(OP_RECV, 8'h00));
              end
            end
            ENG_READ: begin
              read_left = read_left - 21'd1;
              if (read_left == '0) begin
                r = spi_act(OP_DESEL, 8'h00);
                r.done_res = 1'b1;
                eng_phase = ENG_IDLE;
              end else begin
                r = spi_act(OP_RECV, 8'h00);
              end
              r.host_valid = 1'b1;
              r.host_byte = dbyte;
              item_actions.push_back(r);
            end
            ENG_STATUS: begin
              // Write in progress bit still set: poll again
              if (dbyte[0]) begin
                add_status_poll();
              end else begin
                add_done();
                eng_phase = ENG_IDLE;
              end
            end
            default: add_reject();
          endcase
        end
        default: add_reject();
      endcase
    end
    foreach (item_actions[i]) begin
      expected_actions.push_back('{act: item_actions[i],
                                   last: (i == item_actions.size() - 1)});
    end
  endtask

  task compare_field(input string name, input logic [23:0] want, input logic [23:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  task check_action();
    spi_action_t want;
    if (expected_actions.size() == 0) begin
      mismatches++;
      $display("%0t: result with nothing expected: expected none, actual op %0d data %h last %b",
               $time, out_tuser, out_tdata, out_tlast);
    end else begin
      want = expected_actions.pop_front();
      compare_field("spi_op",     24'(want.act.spi_op),     24'(out_tuser));
      compare_field("tx_byte",    24'(want.act.tx_byte),    24'(out_tdata[7:0]));
      compare_field("fill_count", 24'(want.act.fill_count), 24'(out_tdata[16:8]));
      compare_field("host_valid", 24'(want.act.host_valid), 24'(out_tdata[17]));
      compare_field("host_byte",  24'(want.act.host_byte),  24'(out_tdata[25:18]));
      compare_field("id_value",   want.act.id_value,        out_tdata[49:26]);
      compare_field("done_res",   24'(want.act.done_res),   24'(out_tdata[50]));
      compare_field("error",      24'(want.act.error),      24'(out_tdata[51]));
      compare_field("tdata pad",  24'd0,                    24'(out_tdata[55:52]));
      compare_field("last",       24'(want.last),           24'(out_tlast));
    end
  endtask

  // Both channels are sampled at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      eng_phase = ENG_IDLE;
      read_left = '0;
      id_shift = '0;
      id_count = '0;
      fill_left = '0;
      expected_actions.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        plan_actions(in_tuser, in_tdata[23:0], in_tdata[44:24], in_tdata[52:45]);
      end
      if (out_tvalid && out_tready) begin
        check_action();
      end
      outstanding <= expected_actions.size();
    end
  end

endmodule

### dv/tb_spi_flash_command_engine.sv
// ----------------------------------------------------------------------------
// tb_spi_flash_command_engine
// Drives host commands and flash bytes into the SPI flash command engine:
// a directed pass over opcodes, extremes and rejected transactions, then
// well-formed command sequences with random content and injected noise,
// under changing source and sink back-pressure. The checker does the scoring.
// ----------------------------------------------------------------------------
module tb_spi_flash_command_engine
  import sfce_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CYCLE_LIMIT = 600000;
  localparam int         HOLD_CYCLES = 200;
  localparam int         DRAIN_CYCLES = 8;
  localparam logic [2:0] FN_UNDEF = 3'd7;

  typedef enum {CTX_IDLE, CTX_WAIT, CTX_PROG} traffic_ctx_e;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // address[23:0], count[44:24], data_byte[52:45]
  logic [2:0]  in_tuser;   // func
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // tx_byte[7:0], fill_count[16:8], host_valid[17],
                           // host_byte[25:18], id_value[49:26], done_res[50], error[51]
  logic [2:0]  out_tuser;  // spi_op
  logic        out_tlast;

  int mismatches;
  int outstanding;
  int items_sent = 0;
  int src_idle_pct = 12;
  int sink_idle_pct = 71;
  int hold_requests = 0;
  int holds_done = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  spi_flash_command_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sfce_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  // Offer one transaction, with an optional idle gap first
  task automatic drive_item(input logic [2:0] fn, input logic [23:0] addr,
                            input logic [20:0] cnt, input logic [7:0] dbyte);
    if ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tuser <= fn;
    in_tdata <= {3'b000, dbyte, cnt, addr};
    do @(posedge clk); while (!in_tready);
    items_sent++;
  endtask

  // Transactions the engine must reject in the given context
  task automatic inject_noise(input traffic_ctx_e ctx);
    int pick;
    pick = $urandom_range(0, 4);
    if (ctx == CTX_IDLE) begin
      case (pick)
        0: drive_item(FN_PROG_BYTE, 24'($urandom), 21'($urandom), 8'($urandom));
        1: drive_item(FN_FLASH_BYTE, 24'($urandom), 21'($urandom), 8'($urandom));
        2: drive_item(FN_UNDEF, 24'($urandom), 21'($urandom), 8'($urandom));
        3: drive_item(FN_PROG, 24'($urandom), 21'd0, 8'($urandom));
        default: drive_item(FN_PROG, 24'($urandom),
                            21'($urandom_range(PAGE_BYTES_DEF + 1, 21'h1FFFFF)),
                            8'($urandom));
      endcase
    end else begin
      case (pick)
        0, 1, 2: drive_item(3'($urandom_range(0, 4)), 24'($urandom), 21'($urandom),
                            8'($urandom));
        // stray program byte while waiting on flash, stray flash byte mid-page
        3: drive_item((ctx == CTX_PROG) ? FN_FLASH_BYTE : FN_PROG_BYTE, 24'($urandom),
                      21'($urandom), 8'($urandom));
        default: drive_item(FN_UNDEF, 24'($urandom), 21'($urandom), 8'($urandom));
      endcase
    end
  endtask

  task automatic maybe_noise(input traffic_ctx_e ctx);
    if ($urandom_range(99) < 10) inject_noise(ctx);
  endtask

  task automatic flash_byte(input logic [7:0] b);
    drive_item(FN_FLASH_BYTE, 24'($urandom), 21'($urandom), b);
  endtask

  // Status bytes: up to three with write-in-progress set, then one clear
  task automatic run_status_poll();
    int busy_polls;
    busy_polls = $urandom_range(0, 3);
    repeat (busy_polls) begin
      maybe_noise(CTX_WAIT);
      flash_byte({7'($urandom), 1'b1});
    end
    maybe_noise(CTX_WAIT);
    flash_byte({7'($urandom), 1'b0});
  endtask

  task automatic run_program(input int n);
    drive_item(FN_PROG, 24'($urandom), 21'(n), 8'($urandom));
    for (int i = 0; i < n; i++) begin
      maybe_noise(CTX_PROG);
      drive_item(FN_PROG_BYTE, 24'($urandom), 21'($urandom), 8'($urandom));
    end
    run_status_poll();
  endtask

  // One well-formed command sequence, or idle-state noise
  task automatic run_sequence();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      drive_item(FN_READ_ID, 24'($urandom), 21'($urandom), 8'($urandom));
      repeat (3) begin
        maybe_noise(CTX_WAIT);
        flash_byte(8'($urandom));
      end
    end else if (pick < 22) begin
      drive_item(FN_WREN, 24'($urandom), 21'($urandom), 8'($urandom));
    end else if (pick < 36) begin
      drive_item(FN_ERASE, 24'($urandom), 21'($urandom), 8'($urandom));
      run_status_poll();
    end else if (pick < 62) begin
      n = ($urandom_range(99) < 80) ? $urandom_range(0, 6) : $urandom_range(7, 40);
      drive_item(FN_READ, 24'($urandom), 21'(n), 8'($urandom));
      repeat (n) begin
        maybe_noise(CTX_WAIT);
        flash_byte(8'($urandom));
      end
    end else if (pick < 88) begin
      n = $urandom_range(0, 99);
      if (n < 80) n = $urandom_range(1, 6);
      else if (n < 97) n = $urandom_range(7, 24);
      else n = $urandom_range(25, 48);
      run_program(n);
    end else begin
      inject_noise(CTX_IDLE);
    end
  endtask

  // Sink: random ready, plus a long hold-off on request
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= sink_idle_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Read ID with busy, stray and unknown transactions while bytes are due
    drive_item(FN_READ_ID, 24'($urandom), 21'($urandom), 8'($urandom));
    drive_item(FN_WREN, 24'($urandom), 21'($urandom), 8'($urandom));
    drive_item(FN_PROG_BYTE, 24'($urandom), 21'($urandom), 8'($urandom));
    drive_item(FN_UNDEF, 24'($urandom), 21'($urandom), 8'($urandom));
    flash_byte(8'hFF);
    flash_byte(8'h00);
    flash_byte(8'h80);
    drive_item(FN_WREN, 24'($urandom), 21'($urandom), 8'($urandom));
    // Erase at the top address, one busy status then ready
    drive_item(FN_ERASE, 24'hFFFFFF, 21'($urandom), 8'($urandom));
    flash_byte(8'hFF);
    flash_byte(8'hFE);
    // Empty read, then a two-byte read
    drive_item(FN_READ, 24'h000000, 21'd0, 8'($urandom));
    drive_item(FN_READ, 24'h800000, 21'd2, 8'($urandom));
    flash_byte(8'h00);
    flash_byte(8'hFF);
    // Empty and oversized programs
    drive_item(FN_PROG, 24'($urandom), 21'd0, 8'($urandom));
    drive_item(FN_PROG, 24'($urandom), 21'(PAGE_BYTES_DEF + 1), 8'($urandom));
    drive_item(FN_PROG, 24'($urandom), 21'h1FFFFF, 8'($urandom));
    // Single-byte program, widest fill
    drive_item(FN_PROG, 24'h7FFFFF, 21'd1, 8'($urandom));
    drive_item(FN_PROG_BYTE, 24'($urandom), 21'($urandom), 8'h00);
    flash_byte(8'h00);
    // Stray data while idle
    drive_item(FN_PROG_BYTE, 24'($urandom), 21'($urandom), 8'($urandom));
    flash_byte(8'($urandom));

    while (items_sent < 32) run_sequence();
    src_idle_pct = 71;
    sink_idle_pct <= 12;
    while (items_sent < 40) run_sequence();
    src_idle_pct = 0;
    sink_idle_pct <= 0;
    // Sink stalls while the source keeps offering a full page, so no fill
    hold_requests++;
    drive_item(FN_PROG, 24'($urandom), 21'(PAGE_BYTES_DEF), 8'($urandom));
    repeat (PAGE_BYTES_DEF) begin
      drive_item(FN_PROG_BYTE, 24'($urandom), 21'($urandom), 8'($urandom));
    end
    run_status_poll();

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/sfce_pkg.sv
hdl/sfce_ctrl.sv
hdl/sfce_seq.sv
hdl/spi_flash_command_engine.sv
dv/sfce_checker.sv
dv/tb_spi_flash_command_engine.sv
